@@ rtl/csw_pkg.sv @@
package csw_pkg;

    localparam int COUNT_W             = 16;
    localparam int PID_W               = 16;
    localparam int KIND_W              = 3;
    localparam int DEFAULT_MAX_WAITERS = 16;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef enum logic [KIND_W-1:0] {
        KIND_GRANTED = 3'd0,
        KIND_QUEUED  = 3'd1,
        KIND_REFUSED = 3'd2,
        KIND_POSTED  = 3'd3,
        KIND_WOKEN   = 3'd4
    } kind_t;

    typedef enum logic {
        OP_WAIT = 1'b0,
        OP_POST = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_WALK
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;        // capture the incoming item
        logic exec_wait;   // resolve a wait
        logic post_empty;  // post with an empty waiter list
        logic walk_start;  // post with waiters: begin reading the list
        logic walk_step;   // emit one woken waiter
    } csw_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_post;
        logic list_empty;
        logic walk_last;
    } csw_status_t;

endpackage

@@ rtl/csw_ctrl.sv @@
module csw_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  csw_pkg::csw_status_t status,
    output csw_pkg::csw_cmd_t    cmd
);
    import csw_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (status.is_post && !status.list_empty)
                begin
                    state_next = ST_WALK;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_WALK:
            begin
                if (status.walk_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        busy = 1'b1;
        cmd  = '0;
        case (state_reg)
            ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            ST_EXEC:
            begin
                cmd.exec_wait  = !status.is_post;
                cmd.post_empty = status.is_post && status.list_empty;
                cmd.walk_start = status.is_post && !status.list_empty;
            end
            ST_WALK:
            begin
                cmd.walk_step = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

@@ rtl/csw_dp.sv @@
module csw_dp #(
    parameter int MAX_WAITERS = csw_pkg::DEFAULT_MAX_WAITERS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  csw_pkg::csw_cmd_t           cmd,
    output csw_pkg::csw_status_t        status,
    input  logic                        cfg_write,
    input  logic [csw_pkg::COUNT_W-1:0] cfg_data,
    input  logic                        operation,
    input  logic [csw_pkg::PID_W-1:0]   requester_pid,
    output logic                        result_valid,
    output logic [csw_pkg::KIND_W-1:0]  result_kind,
    output logic [csw_pkg::PID_W-1:0]   woken_pid,
    output logic                        last
);
    import csw_pkg::*;

    localparam int IDX_W = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
    localparam int TOT_W = $clog2(MAX_WAITERS + 1);
    localparam logic [TOT_W-1:0] TOTAL_FULL = TOT_W'(MAX_WAITERS);

    logic [PID_W-1:0]   waiter_mem [MAX_WAITERS];
    logic [PID_W-1:0]   rd_data_reg;
    logic [IDX_W-1:0]   rd_addr;

    logic               op_reg;
    logic [PID_W-1:0]   pid_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic [TOT_W-1:0]   total_reg;
    logic [TOT_W-1:0]   total_next;
    logic [IDX_W-1:0]   idx_reg;
    logic [IDX_W-1:0]   idx_next;

    logic               res_valid_reg;
    logic               res_valid_next;
    logic [KIND_W-1:0]  res_kind_reg;
    logic [KIND_W-1:0]  res_kind_next;
    logic [PID_W-1:0]   res_pid_reg;
    logic [PID_W-1:0]   res_pid_next;
    logic               res_last_reg;
    logic               res_last_next;

    logic               mem_we;
    logic               walk_last;

    assign walk_last = (TOT_W'(idx_reg) == total_reg - 1'b1);

    assign status.is_post    = op_reg;
    assign status.list_empty = (total_reg == '0);
    assign status.walk_last  = walk_last;

    // The list is read one entry ahead so that each walk cycle emits a waiter.
    assign rd_addr = cmd.walk_start ? '0 : IDX_W'(idx_reg + 1'b1);
    assign mem_we  = cmd.exec_wait && (count_reg == '0) && (total_reg != TOTAL_FULL);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            waiter_mem[total_reg[IDX_W-1:0]] <= pid_reg;
        end
        rd_data_reg <= waiter_mem[rd_addr];
    end

    always_comb
    begin
        count_next     = count_reg;
        total_next     = total_reg;
        idx_next       = idx_reg;
        res_valid_next = 1'b0;
        res_kind_next  = res_kind_reg;
        res_pid_next   = '0;
        res_last_next  = 1'b1;

        if (cmd.exec_wait)
        begin
            res_valid_next = 1'b1;
            if (count_reg != '0)
            begin
                count_next    = count_reg - 1'b1;
                res_kind_next = KIND_GRANTED;
            end
            else if (total_reg != TOTAL_FULL)
            begin
                total_next    = total_reg + 1'b1;
                res_kind_next = KIND_QUEUED;
            end
            else
            begin
                res_kind_next = KIND_REFUSED;
            end
        end

        if (cmd.post_empty || cmd.walk_start)
        begin
            if (count_reg != COUNT_MAX)
            begin
                count_next = count_reg + 1'b1;
            end
        end

        if (cmd.post_empty)
        begin
            res_valid_next = 1'b1;
            res_kind_next  = KIND_POSTED;
        end

        if (cmd.walk_start)
        begin
            idx_next = '0;
        end

        if (cmd.walk_step)
        begin
            res_valid_next = 1'b1;
            res_kind_next  = KIND_WOKEN;
            res_pid_next   = rd_data_reg;
            res_last_next  = walk_last;
            idx_next       = IDX_W'(idx_reg + 1'b1);
            if (walk_last)
            begin
                total_next = '0;
            end
        end

        // Writing the initial count reloads the semaphore and drops all waiters.
        if (cfg_write)
        begin
            count_next = cfg_data;
            total_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            total_reg     <= '0;
            idx_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            total_reg     <= total_next;
            idx_reg       <= idx_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= operation;
            pid_reg <= requester_pid;
        end
        res_kind_reg <= res_kind_next;
        res_pid_reg  <= res_pid_next;
        res_last_reg <= res_last_next;
    end

    assign result_valid = res_valid_reg;
    assign result_kind  = res_kind_reg;
    assign woken_pid    = res_pid_reg;
    assign last         = res_last_reg;

endmodule

@@ rtl/counting_semaphore_with_waiters.sv @@
// Channel   Handshake              Ports
// -------   ---------------------  -----------------------------------------
// request   start & !busy          operation, requester_pid
// result    result_valid strobe    result_kind, woken_pid, last
// config    cfg_write              cfg_data (initial count)
//
// A wait or a post to an empty list is accepted in the idle state and resolved in the exec
// state; its result shows on the cycle after. A post with waiters then walks the list
// and wakes them one at a time, paced by the single read port of the waiter memory.
// Reset clears the count, the waiter list and the controller at once.
// Results are strobed for one cycle each and the receiver cannot stall them.
module counting_semaphore_with_waiters #(
    parameter int MAX_WAITERS = csw_pkg::DEFAULT_MAX_WAITERS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        operation,
    input  logic [csw_pkg::PID_W-1:0]   requester_pid,
    input  logic                        cfg_write,
    input  logic [csw_pkg::COUNT_W-1:0] cfg_data,
    output logic                        result_valid,
    output logic [csw_pkg::KIND_W-1:0]  result_kind,
    output logic [csw_pkg::PID_W-1:0]   woken_pid,
    output logic                        last
);
    import csw_pkg::*;

    csw_cmd_t    cmd;
    csw_status_t status;

    csw_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .status (status),
        .cmd    (cmd)
    );

    csw_dp #(
        .MAX_WAITERS (MAX_WAITERS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg_write     (cfg_write),
        .cfg_data      (cfg_data),
        .operation     (operation),
        .requester_pid (requester_pid),
        .result_valid  (result_valid),
        .result_kind   (result_kind),
        .woken_pid     (woken_pid),
        .last          (last)
    );

endmodule
